// File: sv/im2col_pkg.sv
// Shared types and constants for the dilated im2col feeder.
`timescale 1ns / 1ps

package im2col_pkg;

  // Field widths of the beats and the configuration port
  localparam int ELEM_W      = 32;
  localparam int PIXEL_W     = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 14;
  // Largest linear image address before wrapping: 16 * 127 * 127 words
  localparam int ADDR_FULL_W = 18;

  // Operation codes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_SHAPE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_SHAPE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SPREAD_SHAPE  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_LEAD_PADDING  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_SHAPE  = 3'd7;

  // Register reset values
  localparam logic [4:0]  RST_CHANNEL_COUNT = 5'd1;
  localparam logic [6:0]  RST_IMAGE_HEIGHT  = 7'd8;
  localparam logic [6:0]  RST_IMAGE_WIDTH   = 7'd8;
  localparam logic [7:0]  RST_KERNEL_SHAPE  = 8'd51;
  localparam logic [7:0]  RST_STEP_SHAPE    = 8'd17;
  localparam logic [7:0]  RST_SPREAD_SHAPE  = 8'd17;
  localparam logic [7:0]  RST_LEAD_PADDING  = 8'd0;
  localparam logic [13:0] RST_OUTPUT_SHAPE  = 14'd774;

  // Input beat
  typedef struct packed {
    logic               operation;
    logic [PIXEL_W-1:0] pixel;
  } in_beat_t;

  // Output beat
  typedef struct packed {
    logic [ELEM_W-1:0] element;
    logic              in_padding;
    logic              last;
  } out_beat_t;

endpackage

// File: sv/im2col_channel_major_dilated_core.sv
// Top level of the dilated, padded im2col feeder with channel-major column order.
`timescale 1ns / 1ps

// Loads write image words into a single-port image memory in channel, row, column
// order; fetches walk the column matrix (channel, kernel row, kernel column, output
// row, output column) and return one element each, zero with in_padding set when the
// dilated, strided position falls outside the image, and last on the final element.
// Every item runs through a six-stage pipeline: stride and dilation products, row and
// column bounds checks, linear address, reduction modulo IMAGE_WORDS (multiply by a
// constant reciprocal, then subtract), and finally the memory access, whose registered
// read data is the output register. Loads write in that same last stage, so a fetch
// always sees every earlier load. One item is taken per cycle; a stalled output
// freezes the whole pipeline. The memory is not cleared after reset: fetching a word
// never loaded gives an undefined element. Register writes apply at once, also to items
// in flight, as the block does not hold them back: the user must write them only
// once the pipeline has drained.
module im2col_channel_major_dilated_core #(
  parameter int IMAGE_WORDS = 4096,
  parameter int DATA_BITS   = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  im2col_pkg::in_beat_t                  in_beat_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output im2col_pkg::out_beat_t                 out_beat_o,
  input  logic                                  cfg_we_i,
  input  logic [im2col_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [im2col_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int AF_W    = im2col_pkg::ADDR_FULL_W;
  localparam int ADDR_W  = $clog2(IMAGE_WORDS);
  // Reciprocal for the exact modulo: quotient = (a * RCP_M) >> RCP_SH for a < 2**AF_W
  localparam int RCP_SH  = AF_W + ADDR_W;
  localparam int RCP_W   = AF_W + 2;
  localparam int PROD_W  = AF_W + RCP_W;
  localparam int QUOT_W  = PROD_W - RCP_SH;
  localparam int QD_W    = QUOT_W + ADDR_W + 1;
  localparam logic [63:0] RCP_M64 =
      ((64'd1 << RCP_SH) + 64'(IMAGE_WORDS) - 64'd1) / 64'(IMAGE_WORDS);
  localparam logic [RCP_W-1:0]  RCP_M = RCP_M64[RCP_W-1:0];
  localparam logic [ADDR_W:0]   IMG_D = (ADDR_W+1)'(IMAGE_WORDS);

  typedef struct packed {
    logic                 op;
    logic [DATA_BITS-1:0] pixel;
    logic [9:0]           prs;   // output row * vertical stride
    logic [7:0]           prk;   // kernel row * vertical dilation
    logic [9:0]           pcs;   // output column * horizontal stride
    logic [7:0]           pck;   // kernel column * horizontal dilation
    logic [10:0]          chh;   // channel * height
    logic [10:0]          cxh;   // channels * height
    logic                 last;
  } s0_t;

  typedef struct packed {
    logic                 op;
    logic [DATA_BITS-1:0] pixel;
    logic [10:0]          base;  // channel * height + row
    logic [6:0]           col;
    logic                 pad;
    logic                 last;
    logic [AF_W-1:0]      total; // words per image
  } s1_t;

  typedef struct packed {
    logic                 op;
    logic [DATA_BITS-1:0] pixel;
    logic [AF_W-1:0]      addr;
    logic                 pad;
    logic                 last;
  } s2_t;

  typedef struct packed {
    logic                 op;
    logic [DATA_BITS-1:0] pixel;
    logic [AF_W-1:0]      addr;
    logic [QUOT_W-1:0]    quot;
    logic                 pad;
    logic                 last;
  } s3_t;

  typedef struct packed {
    logic                 op;
    logic [DATA_BITS-1:0] pixel;
    logic [ADDR_W-1:0]    idx;
    logic                 pad;
    logic                 last;
  } s4_t;

  // Configuration registers
  logic [4:0]  chan_cnt_q;
  logic [6:0]  img_h_q;
  logic [6:0]  img_w_q;
  logic [7:0]  kern_q;
  logic [7:0]  step_q;
  logic [7:0]  spread_q;
  logic [7:0]  lead_q;
  logic [13:0] out_shape_q;

  // Fetch walk counters and load pointer
  logic [3:0]        chan_q, krow_q, kcol_q;
  logic [5:0]        orow_q, ocol_q;
  logic [ADDR_W-1:0] lp_q;

  // Pipeline
  logic adv;
  logic s0_vld_q, s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q, out_vld_q;
  s0_t  s0_d, s0_q;
  s1_t  s1_d, s1_q;
  s2_t  s2_d, s2_q;
  s3_t  s3_d, s3_q;
  s4_t  s4_q;
  logic [ADDR_W-1:0] idx_d;

  // Image memory and its read register
  logic [DATA_BITS-1:0] img_mem [IMAGE_WORDS];
  logic [DATA_BITS-1:0] rd_q;
  logic                 pad_q;
  logic                 last_q;

  // Derived shapes
  logic [4:0] chans;
  logic [3:0] krows, kcols;
  logic [6:0] orows, ocols;
  logic [3:0] sv, sh, dv, dh, pt, pl;

  logic ch_end, kr_end, kc_end, orow_end, ocol_end, is_last, fetch_acc;

  logic [10:0] row_sum, row_off, col_sum, col_off;
  logic        row_in, col_in;

  logic [ADDR_W:0]  lp_next;
  logic             lp_wrap;
  logic             load_adv;

  logic [PROD_W-1:0] rcp_prod;
  logic [QD_W-1:0]   qd_full;
  logic [AF_W-1:0]   rem_full;

  // Whole pipeline moves when the output register is free or being drained
  assign adv        = !out_vld_q || out_ready_i;
  assign in_ready_o = adv;
  assign fetch_acc  = in_valid_i && adv && (in_beat_i.operation == im2col_pkg::OP_FETCH);
  assign load_adv   = adv && s1_vld_q && (s1_q.op == im2col_pkg::OP_LOAD);

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_cnt_q  <= im2col_pkg::RST_CHANNEL_COUNT;
      img_h_q     <= im2col_pkg::RST_IMAGE_HEIGHT;
      img_w_q     <= im2col_pkg::RST_IMAGE_WIDTH;
      kern_q      <= im2col_pkg::RST_KERNEL_SHAPE;
      step_q      <= im2col_pkg::RST_STEP_SHAPE;
      spread_q    <= im2col_pkg::RST_SPREAD_SHAPE;
      lead_q      <= im2col_pkg::RST_LEAD_PADDING;
      out_shape_q <= im2col_pkg::RST_OUTPUT_SHAPE;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        im2col_pkg::CFG_CHANNEL_COUNT: chan_cnt_q  <= cfg_data_i[4:0];
        im2col_pkg::CFG_IMAGE_HEIGHT:  img_h_q     <= cfg_data_i[6:0];
        im2col_pkg::CFG_IMAGE_WIDTH:   img_w_q     <= cfg_data_i[6:0];
        im2col_pkg::CFG_KERNEL_SHAPE:  kern_q      <= cfg_data_i[7:0];
        im2col_pkg::CFG_STEP_SHAPE:    step_q      <= cfg_data_i[7:0];
        im2col_pkg::CFG_SPREAD_SHAPE:  spread_q    <= cfg_data_i[7:0];
        im2col_pkg::CFG_LEAD_PADDING:  lead_q      <= cfg_data_i[7:0];
        im2col_pkg::CFG_OUTPUT_SHAPE:  out_shape_q <= cfg_data_i[13:0];
        default: ;
      endcase
    end
  end

  // Clamp zero and oversized counts
  always_comb begin
    if (chan_cnt_q == 5'd0)       chans = 5'd1;
    else if (chan_cnt_q > 5'd16)  chans = 5'd16;
    else                          chans = chan_cnt_q;
    krows = (kern_q[3:0] == 4'd0) ? 4'd1 : kern_q[3:0];
    kcols = (kern_q[7:4] == 4'd0) ? 4'd1 : kern_q[7:4];
    if (out_shape_q[6:0] == 7'd0)       orows = 7'd1;
    else if (out_shape_q[6:0] > 7'd64)  orows = 7'd64;
    else                                orows = out_shape_q[6:0];
    if (out_shape_q[13:7] == 7'd0)      ocols = 7'd1;
    else if (out_shape_q[13:7] > 7'd64) ocols = 7'd64;
    else                                ocols = out_shape_q[13:7];
  end

  assign sv = step_q[3:0];
  assign sh = step_q[7:4];
  assign dv = spread_q[3:0];
  assign dh = spread_q[7:4];
  assign pt = lead_q[3:0];
  assign pl = lead_q[7:4];

  // Counter end conditions; a counter past its bound also wraps
  assign ch_end   = (5'(chan_q) + 5'd1) >= chans;
  assign kr_end   = (5'(krow_q) + 5'd1) >= 5'(krows);
  assign kc_end   = (5'(kcol_q) + 5'd1) >= 5'(kcols);
  assign orow_end = (7'(orow_q) + 7'd1) >= orows;
  assign ocol_end = (7'(ocol_q) + 7'd1) >= ocols;
  assign is_last  = ch_end && kr_end && kc_end && orow_end && ocol_end;

  // Walk counters, output column fastest
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_q <= '0;
      krow_q <= '0;
      kcol_q <= '0;
      orow_q <= '0;
      ocol_q <= '0;
    end else if (fetch_acc) begin
      ocol_q <= ocol_end ? '0 : ocol_q + 6'd1;
      if (ocol_end) begin
        orow_q <= orow_end ? '0 : orow_q + 6'd1;
      end
      if (ocol_end && orow_end) begin
        kcol_q <= kc_end ? '0 : kcol_q + 4'd1;
      end
      if (ocol_end && orow_end && kc_end) begin
        krow_q <= kr_end ? '0 : krow_q + 4'd1;
      end
      if (ocol_end && orow_end && kc_end && kr_end) begin
        chan_q <= ch_end ? '0 : chan_q + 4'd1;
      end
    end
  end

  // Stage 0: products of positions and steps
  always_comb begin
    s0_d.op    = in_beat_i.operation;
    s0_d.pixel = DATA_BITS'(in_beat_i.pixel);
    s0_d.prs   = 10'(orow_q) * 10'(sv);
    s0_d.prk   = 8'(krow_q) * 8'(dv);
    s0_d.pcs   = 10'(ocol_q) * 10'(sh);
    s0_d.pck   = 8'(kcol_q) * 8'(dh);
    s0_d.chh   = 11'(chan_q) * 11'(img_h_q);
    s0_d.cxh   = 11'(chans) * 11'(img_h_q);
    s0_d.last  = is_last;
  end

  // Stage 1: remove the lead pad, bounds check, row base
  always_comb begin
    row_sum    = 11'(s0_q.prs) + 11'(s0_q.prk);
    row_off    = row_sum - 11'(pt);
    row_in     = (row_sum >= 11'(pt)) && (row_off < 11'(img_h_q));
    col_sum    = 11'(s0_q.pcs) + 11'(s0_q.pck);
    col_off    = col_sum - 11'(pl);
    col_in     = (col_sum >= 11'(pl)) && (col_off < 11'(img_w_q));
    s1_d.op    = s0_q.op;
    s1_d.pixel = s0_q.pixel;
    s1_d.base  = s0_q.chh + 11'(row_off[6:0]);
    s1_d.col   = col_off[6:0];
    s1_d.pad   = !(row_in && col_in);
    s1_d.last  = s0_q.last;
    s1_d.total = AF_W'(s0_q.cxh) * AF_W'(img_w_q);
  end

  // Stage 2: linear address; loads take the load pointer
  always_comb begin
    lp_next    = {1'b0, lp_q} + (ADDR_W+1)'(1);
    lp_wrap    = (AF_W'(lp_next) >= s1_q.total) || (lp_next >= IMG_D);
    s2_d.op    = s1_q.op;
    s2_d.pixel = s1_q.pixel;
    s2_d.pad   = s1_q.pad;
    s2_d.last  = s1_q.last;
    if (s1_q.op == im2col_pkg::OP_LOAD) begin
      s2_d.addr = AF_W'(lp_q);
    end else begin
      s2_d.addr = AF_W'(s1_q.base) * AF_W'(img_w_q) + AF_W'(s1_q.col);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lp_q <= '0;
    end else if (load_adv) begin
      lp_q <= lp_wrap ? '0 : lp_next[ADDR_W-1:0];
    end
  end

  // Stage 3: quotient by the store depth through the reciprocal
  always_comb begin
    rcp_prod   = PROD_W'(s2_q.addr) * PROD_W'(RCP_M);
    s3_d.op    = s2_q.op;
    s3_d.pixel = s2_q.pixel;
    s3_d.addr  = s2_q.addr;
    s3_d.quot  = rcp_prod[PROD_W-1:RCP_SH];
    s3_d.pad   = s2_q.pad;
    s3_d.last  = s2_q.last;
  end

  // Stage 4: remainder is the memory index
  always_comb begin
    qd_full  = QD_W'(s3_q.quot) * QD_W'(IMG_D);
    rem_full = s3_q.addr - qd_full[AF_W-1:0];
    idx_d    = rem_full[ADDR_W-1:0];
  end

  // Stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q  <= 1'b0;
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      s4_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      s0_vld_q  <= in_valid_i;
      s1_vld_q  <= s0_vld_q;
      s2_vld_q  <= s1_vld_q;
      s3_vld_q  <= s2_vld_q;
      s4_vld_q  <= s3_vld_q;
      out_vld_q <= s4_vld_q && (s4_q.op == im2col_pkg::OP_FETCH);
    end
  end

  // Stage payloads
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_q       <= s0_d;
      s1_q       <= s1_d;
      s2_q       <= s2_d;
      s3_q       <= s3_d;
      s4_q.op    <= s3_q.op;
      s4_q.pixel <= s3_q.pixel;
      s4_q.idx   <= idx_d;
      s4_q.pad   <= s3_q.pad;
      s4_q.last  <= s3_q.last;
    end
  end

  // Stage 5: memory write for loads, registered read for fetches
  always_ff @(posedge clk_i) begin
    if (adv && s4_vld_q) begin
      if (s4_q.op == im2col_pkg::OP_LOAD) begin
        img_mem[s4_q.idx] <= s4_q.pixel;
      end else begin
        rd_q   <= img_mem[s4_q.idx];
        pad_q  <= s4_q.pad;
        last_q <= s4_q.last;
      end
    end
  end

  // Output beat
  assign out_valid_o           = out_vld_q;
  assign out_beat_o.element    = pad_q ? '0 : im2col_pkg::ELEM_W'(rd_q);
  assign out_beat_o.in_padding = pad_q;
  assign out_beat_o.last       = last_q;

endmodule

// File: sv/im2col_chk.sv
// Port-level checks for the im2col feeder, bound to its top level.
`timescale 1ns / 1ps

module im2col_chk (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_ready_o,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input im2col_pkg::out_beat_t out_beat_o
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_beat_o))
    else $error("output beat changed while stalled");

  // Input side is open whenever no result is waiting
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input not ready with empty output");

  // A waiting result blocks new input beats
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input accepted while output stalled");

  // Padding elements read as zero
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_beat_o.in_padding |-> out_beat_o.element == '0)
    else $error("padding element is not zero");

endmodule

bind im2col_channel_major_dilated_core im2col_chk u_im2col_chk (.*);
